// ----- rtl/rpn_pkg.sv -----
// Shared constants, codes, types and helpers for the postfix evaluator.
`default_nettype none
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int PROD_W      = 2 * DATA_W;
   localparam int DIV_W       = DATA_W + FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_OPER = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DIVZERO   = 3'd3;
   localparam logic [2:0] ST_SAT       = 3'd4;
   localparam logic [2:0] ST_RESULT    = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;
   localparam logic [2:0] ST_EXTRA     = 3'd7;

   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic              sat;
      logic [DATA_W-1:0] value;
   } sat_result_type;

   // Magnitude of a two's complement value; the most negative maps to 2^31.
   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
      mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
   endfunction

   // Sign and magnitude back to a saturated signed word.
   function automatic sat_result_type from_mag(input logic neg,
                                               input logic [PROD_W-1:0] m);
      sat_result_type r;
      r.sat   = 1'b0;
      r.value = '0;
      if (neg) begin
         if (m > PROD_W'(MIN_VAL)) begin
            r.sat   = 1'b1;
            r.value = MIN_VAL;
         end else begin
            r.value = ~m[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (m > PROD_W'(MAX_VAL)) begin
            r.sat   = 1'b1;
            r.value = MAX_VAL;
         end else begin
            r.value = m[DATA_W-1:0];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rpn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/rpn_div.sv -----
// Restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) / divisor.
`default_nettype none
module rpn_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rpn_pkg::DATA_W-1:0]  dividend,
   input  wire logic [rpn_pkg::DATA_W-1:0]  divisor,
   output logic                             done,
   output logic      [rpn_pkg::DIV_W-1:0]   quotient
);

   logic [rpn_pkg::DIV_W-1:0]     num_ff, num_in;
   logic [rpn_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [rpn_pkg::DATA_W-1:0]    dvs_ff, dvs_in;
   logic [rpn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [rpn_pkg::DATA_W:0]      trial;
   logic [rpn_pkg::DATA_W:0]      diff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      // remainder stays below divisor, so the shifted trial fits in 33 bits
      trial   = {rem_ff, num_ff[rpn_pkg::DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         num_in = rpn_pkg::DIV_W'(dividend) << rpn_pkg::FRAC_BITS;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[rpn_pkg::DATA_W]) begin
            rem_in = diff[rpn_pkg::DATA_W-1:0];
            num_in = {num_ff[rpn_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[rpn_pkg::DATA_W-1:0];
            num_in = {num_ff[rpn_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - rpn_pkg::DIV_CNT_W'(1);
         if (cnt_ff == rpn_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule
`default_nettype wire

// ----- rtl/rpn_stack_evaluator_top.sv -----
// Postfix expression evaluator: operand stack in RAM, fixed-point ALU, serial divider.
//
//  channel   ports                                          transfer when
//  request   start, busy, req_action/operand/operator       start && !busy
//  response  rsp_valid, rsp_value, rsp_status               rsp_valid (one cycle)
//
// Push, unused actions, underflow and end with zero or extra entries: response
// the cycle after the transfer, busy stays low (one item per cycle).
// End with one entry: state S_END (one stack RAM read). Add/subtract: states
// S_RHS and S_LHS, which fetch the operands by two serial reads of the single RAM
// read port; multiply adds S_MUL. Divide: S_RHS, S_LHS, then S_DIV until the
// bit-serial divider is done; divide by zero finishes in S_LHS.
// Synchronous reset empties the stack; RAM contents are not cleared.
// Responses cannot be held off by the receiver.
`default_nettype none
module rpn_stack_evaluator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_action,
   input  wire logic signed [rpn_pkg::DATA_W-1:0] req_operand,
   input  wire logic [1:0]                       req_operator,
   output logic                                  rsp_valid,
   output logic signed [rpn_pkg::DATA_W-1:0]     rsp_value,
   output logic [2:0]                            rsp_status
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RHS  = 3'd1;
   localparam logic [2:0] S_LHS  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [rpn_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [1:0]                    op_ff, op_in;
   logic [rpn_pkg::DATA_W-1:0]    rhs_ff, rhs_in;
   logic                          neg_ff, neg_in;
   logic [rpn_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rpn_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [2:0]                    rsp_status_ff, rsp_status_in;

   logic                          wr_en;
   logic [rpn_pkg::PTR_W-1:0]     wr_addr;
   logic [rpn_pkg::DATA_W-1:0]    wr_data;
   logic [rpn_pkg::PTR_W-1:0]     rd_addr;
   logic [rpn_pkg::DATA_W-1:0]    rd_data;

   logic                          div_start;
   logic                          div_done;
   logic [rpn_pkg::DIV_W-1:0]     div_quo;

   logic [rpn_pkg::CNT_W-1:0]     cnt_m1;
   logic [rpn_pkg::CNT_W-1:0]     cnt_m2;
   logic                          accept;
   logic [rpn_pkg::DATA_W:0]      sum;
   logic [rpn_pkg::DATA_W-1:0]    lhs_mag;
   logic [rpn_pkg::DATA_W-1:0]    rhs_mag;
   rpn_pkg::sat_result_type       fm;

   assign accept  = start && (state_ff == S_IDLE);
   assign cnt_m1  = count_ff - rpn_pkg::CNT_W'(1);
   assign cnt_m2  = count_ff - rpn_pkg::CNT_W'(2);
   assign lhs_mag = rpn_pkg::mag(rd_data);
   assign rhs_mag = rpn_pkg::mag(rhs_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      rhs_in        = rhs_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = rpn_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = cnt_m2[rpn_pkg::PTR_W-1:0];
      wr_data       = '0;
      rd_addr       = cnt_m1[rpn_pkg::PTR_W-1:0];
      div_start     = 1'b0;
      sum           = '0;
      fm            = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_action == rpn_pkg::ACT_END) begin
               rd_addr = '0;
            end
            if (accept) begin
               op_in = req_operator;
               case (req_action)
                  rpn_pkg::ACT_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[rpn_pkg::PTR_W-1:0];
                        wr_data  = req_operand;
                        count_in = count_ff + rpn_pkg::CNT_W'(1);
                     end else begin
                        rsp_status_in = rpn_pkg::ST_FULL;
                     end
                  end
                  rpn_pkg::ACT_OPER: begin
                     if (count_ff < rpn_pkg::CNT_W'(2)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rpn_pkg::ST_UNDERFLOW;
                     end else begin
                        state_in = S_RHS;
                     end
                  end
                  rpn_pkg::ACT_END: begin
                     count_in = '0;
                     if (count_ff == rpn_pkg::CNT_W'(1)) begin
                        state_in = S_END;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = (count_ff == '0) ? rpn_pkg::ST_EMPTY
                                                         : rpn_pkg::ST_EXTRA;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_END: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = rpn_pkg::ST_RESULT;
            rsp_value_in  = rd_data;
            state_in      = S_IDLE;
         end

         S_RHS: begin
            // rhs arrives now; fetch lhs one entry below
            rhs_in   = rd_data;
            rd_addr  = cnt_m2[rpn_pkg::PTR_W-1:0];
            state_in = S_LHS;
         end

         S_LHS: begin
            neg_in  = rd_data[rpn_pkg::DATA_W-1] ^ rhs_ff[rpn_pkg::DATA_W-1];
            prod_in = rpn_pkg::PROD_W'(lhs_mag) * rpn_pkg::PROD_W'(rhs_mag);
            case (op_ff)
               rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
                  if (op_ff == rpn_pkg::OP_ADD) begin
                     sum = {rd_data[rpn_pkg::DATA_W-1], rd_data}
                         + {rhs_ff[rpn_pkg::DATA_W-1], rhs_ff};
                  end else begin
                     sum = {rd_data[rpn_pkg::DATA_W-1], rd_data}
                         - {rhs_ff[rpn_pkg::DATA_W-1], rhs_ff};
                  end
                  wr_en        = 1'b1;
                  rsp_valid_in = 1'b1;
                  count_in     = cnt_m1;
                  state_in     = S_IDLE;
                  if (sum[rpn_pkg::DATA_W] != sum[rpn_pkg::DATA_W-1]) begin
                     wr_data       = sum[rpn_pkg::DATA_W] ? rpn_pkg::MIN_VAL
                                                          : rpn_pkg::MAX_VAL;
                     rsp_status_in = rpn_pkg::ST_SAT;
                  end else begin
                     wr_data = sum[rpn_pkg::DATA_W-1:0];
                  end
               end
               rpn_pkg::OP_MUL: begin
                  state_in = S_MUL;
               end
               default: begin
                  if (rhs_ff == '0) begin
                     wr_en         = 1'b1;
                     wr_data       = rd_data[rpn_pkg::DATA_W-1] ? rpn_pkg::MIN_VAL
                                                                : rpn_pkg::MAX_VAL;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rpn_pkg::ST_DIVZERO;
                     count_in      = cnt_m1;
                     state_in      = S_IDLE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            endcase
         end

         S_MUL: begin
            fm            = rpn_pkg::from_mag(neg_ff, prod_ff >> rpn_pkg::FRAC_BITS);
            wr_en         = 1'b1;
            wr_data       = fm.value;
            rsp_valid_in  = 1'b1;
            rsp_status_in = fm.sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
            count_in      = cnt_m1;
            state_in      = S_IDLE;
         end

         S_DIV: begin
            if (div_done) begin
               fm            = rpn_pkg::from_mag(neg_ff, rpn_pkg::PROD_W'(div_quo));
               wr_en         = 1'b1;
               wr_data       = fm.value;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fm.sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
               count_in      = cnt_m1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      rhs_ff        <= rhs_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   rpn_ram #(
      .WIDTH (rpn_pkg::DATA_W),
      .DEPTH (rpn_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lhs_mag),
      .divisor  (rhs_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ----- rtl/rpn_chk.sv -----
// Port-level checks for the postfix evaluator, bound to the top level.
`default_nettype none
module rpn_chk (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic [1:0]                       req_action,
   input wire logic signed [rpn_pkg::DATA_W-1:0] req_operand,
   input wire logic [1:0]                       req_operator,
   input wire logic                             rsp_valid,
   input wire logic signed [rpn_pkg::DATA_W-1:0] rsp_value,
   input wire logic [2:0]                       rsp_status
);

   // every transfer yields a response next cycle or holds the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("transfer produced neither response nor busy");

   // a response is never issued while the block is busy
   a_no_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response while busy");

   // finishing a long operation always issues its response
   a_fall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // value carries data only for a final result
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rpn_pkg::ST_RESULT) |-> rsp_value == '0)
      else $error("nonzero value on non-result status");

   // request fields are known on every transfer
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> !$isunknown({req_action, req_operand, req_operator}))
      else $error("unknown request field at transfer");

endmodule

bind rpn_stack_evaluator_top rpn_chk u_chk (.*);
`default_nettype wire

// ----- verif/tb_rpn_stack_evaluator_top.sv -----
// Self-checking testbench for the postfix evaluator: directed table, then random expressions, deep stacks and noise.
module tb_rpn_stack_evaluator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpn_pkg::*;

   localparam logic [1:0] ACT_UNUSED     = 2'd3;
   localparam int         RANDOM_TOKENS  = 1150;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 60;
   localparam int         SCRIPT_ROWS    = 25;
   localparam longint     WORD_MAX       = 64'sd2147483647;
   localparam longint     WORD_MIN       = -64'sd2147483648;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [2:0]        status;
   } eval_result_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [DATA_W-1:0] operand;
      logic [1:0]        oper;
      logic              typed_in;
      logic [DATA_W-1:0] value;
      logic [2:0]        status;
   } script_row_type;

   // Rows with typed_in set carry their expected response; the rest use the predictor.
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ACT_END,    32'h0000_0000, OP_ADD, 1'b1, 32'h0,   ST_EMPTY},
      '{ACT_OPER,   32'h0000_0000, OP_SUB, 1'b1, 32'h0,   ST_UNDERFLOW},
      '{ACT_PUSH,   MAX_VAL,       OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_MUL, 1'b1, 32'h0,   ST_UNDERFLOW},
      '{ACT_PUSH,   32'h0000_0001, OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_ADD, 1'b1, 32'h0,   ST_SAT},
      '{ACT_PUSH,   32'h0000_0000, OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_DIV, 1'b1, 32'h0,   ST_DIVZERO},
      '{ACT_END,    32'h0000_0000, OP_ADD, 1'b1, MAX_VAL, ST_RESULT},
      '{ACT_PUSH,   MIN_VAL,       OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_PUSH,   32'h0000_0001, OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_SUB, 1'b1, 32'h0,   ST_SAT},
      '{ACT_PUSH,   32'h0000_0000, OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_DIV, 1'b1, 32'h0,   ST_DIVZERO},
      '{ACT_PUSH,   32'h0002_0000, OP_ADD, 1'b1, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_MUL, 1'b1, 32'h0,   ST_SAT},
      '{ACT_PUSH,   32'h0003_0000, OP_ADD, 1'b0, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_DIV, 1'b0, 32'h0,   ST_OK},
      '{ACT_PUSH,   32'hFFFF_0000, OP_ADD, 1'b0, 32'h0,   ST_OK},
      '{ACT_OPER,   32'h0000_0000, OP_MUL, 1'b0, 32'h0,   ST_OK},
      '{ACT_PUSH,   32'h0001_8000, OP_ADD, 1'b0, 32'h0,   ST_OK},
      '{ACT_END,    32'h0000_0000, OP_ADD, 1'b1, 32'h0,   ST_EXTRA},
      '{ACT_UNUSED, 32'hFFFF_FFFF, OP_DIV, 1'b1, 32'h0,   ST_OK},
      '{ACT_PUSH,   32'hFFFF_FFFF, OP_DIV, 1'b0, 32'h0,   ST_OK},
      '{ACT_END,    32'h0000_0000, OP_ADD, 1'b0, 32'h0,   ST_OK}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_action;
   logic signed [DATA_W-1:0] req_operand;
   logic [1:0]               req_operator;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_value;
   logic [2:0]               rsp_status;

   // Predictor state: its own copy of the operand stack.
   logic signed [DATA_W-1:0] model_stack [STACK_DEPTH];
   int unsigned              model_depth;

   eval_result_type responses_due[$];
   int              failures;
   int              stall_cycles;
   int              random_tokens;
   bit              burst;

   rpn_stack_evaluator_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_operand  (req_operand),
      .req_operator (req_operator),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] magnitude(input logic signed [DATA_W-1:0] v);
      return v < 0 ? 64'(-longint'(v)) : 64'(longint'(v));
   endfunction

   function automatic logic signed [DATA_W-1:0] clip_sum(input longint w, inout bit sat);
      if (w > WORD_MAX) begin
         sat = 1'b1;
         return MAX_VAL;
      end
      if (w < WORD_MIN) begin
         sat = 1'b1;
         return MIN_VAL;
      end
      return w[DATA_W-1:0];
   endfunction

   // Apply a sign to a truncated magnitude, clipping to the word range.
   function automatic logic signed [DATA_W-1:0] signed_clip(input bit neg,
                                                           input logic [63:0] m,
                                                           inout bit sat);
      if (neg) begin
         if (m > 64'h8000_0000) begin
            sat = 1'b1;
            return MIN_VAL;
         end
         return -m[DATA_W-1:0];
      end
      if (m > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return MAX_VAL;
      end
      return m[DATA_W-1:0];
   endfunction

   function automatic eval_result_type evaluate_token(input logic [1:0] action,
                                                      input logic signed [DATA_W-1:0] operand,
                                                      input logic [1:0] oper);
      eval_result_type          r;
      logic signed [DATA_W-1:0] lhs, rhs, outv;
      bit                       sat, neg;
      r.value  = '0;
      r.status = ST_OK;
      sat      = 1'b0;
      outv     = '0;
      case (action)
         ACT_PUSH: begin
            if (model_depth < STACK_DEPTH) begin
               model_stack[model_depth] = operand;
               model_depth++;
            end else begin
               r.status = ST_FULL;
            end
         end
         ACT_OPER: begin
            if (model_depth < 2) begin
               r.status = ST_UNDERFLOW;
            end else begin
               rhs = model_stack[model_depth-1];
               lhs = model_stack[model_depth-2];
               neg = lhs[DATA_W-1] ^ rhs[DATA_W-1];
               case (oper)
                  OP_ADD: outv = clip_sum(longint'(lhs) + longint'(rhs), sat);
                  OP_SUB: outv = clip_sum(longint'(lhs) - longint'(rhs), sat);
                  OP_MUL: outv = signed_clip(neg,
                                    (magnitude(lhs) * magnitude(rhs)) >> FRAC_BITS, sat);
                  OP_DIV: begin
                     if (rhs == 0) begin
                        outv     = lhs < 0 ? MIN_VAL : MAX_VAL;
                        r.status = ST_DIVZERO;
                     end else begin
                        outv = signed_clip(neg,
                                  (magnitude(lhs) << FRAC_BITS) / magnitude(rhs), sat);
                     end
                  end
               endcase
               if (sat && r.status == ST_OK) r.status = ST_SAT;
               model_depth--;
               model_stack[model_depth-1] = outv;
            end
         end
         ACT_END: begin
            if (model_depth == 0) begin
               r.status = ST_EMPTY;
            end else if (model_depth == 1) begin
               r.status = ST_RESULT;
               r.value  = model_stack[0];
            end else begin
               r.status = ST_EXTRA;
            end
            model_depth = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] raw;
      logic signed [15:0] whole;
      raw   = $urandom_range(0, 32'h000F_FFFF);
      whole = 16'($urandom_range(0, 200)) - 16'sd100;
      case ($urandom_range(0, 7))
         0:       return MAX_VAL;
         1:       return MIN_VAL;
         2:       return '0;
         3, 4:    return raw - 32'h0008_0000;
         5:       return {whole, 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Drive one token after a random gap, or none in burst mode, and hold it until the transfer.
   task automatic issue_token(input logic [1:0] action, input logic [DATA_W-1:0] operand,
                              input logic [1:0] oper, input bit typed_in,
                              input logic [DATA_W-1:0] value, input logic [2:0] status);
      int              gap;
      eval_result_type predicted;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= action;
      req_operand  <= operand;
      req_operator <= oper;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = evaluate_token(action, operand, oper);
      if (typed_in) begin
         predicted.value  = value;
         predicted.status = status;
      end
      responses_due.push_back(predicted);
      if (action != ACT_UNUSED) random_tokens++;
   endtask

   task automatic issue_random(input logic [1:0] action);
      issue_token(action, pick_operand(), 2'($urandom_range(0, 3)), 1'b0, '0, ST_OK);
   endtask

   task automatic wait_all_responses();
      @(negedge clock);
      start <= 1'b0;
      while (responses_due.size() != 0) @(posedge clock);
   endtask

   // Well-formed expression: operators only when at least two entries are on the stack.
   task automatic run_expression();
      int leaves, pushed, depth;
      leaves = $urandom_range(1, 6);
      pushed = 0;
      depth  = 0;
      while (pushed < leaves || depth > 1) begin
         if (pushed < leaves && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            issue_random(ACT_PUSH);
            pushed++;
            depth++;
         end else begin
            issue_random(ACT_OPER);
            depth--;
         end
      end
      issue_random(ACT_END);
   endtask

   // Push from two below to two past the stack limit, fold some of it, then close.
   task automatic run_deep_stack();
      int pushes, folds;
      pushes = $urandom_range(14, 18);
      folds  = $urandom_range(0, pushes);
      repeat (pushes) issue_random(ACT_PUSH);
      repeat (folds) issue_random(ACT_OPER);
      issue_random(ACT_END);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 8)) issue_random(2'($urandom_range(0, 3)));
   endtask

   always @(posedge clock) begin
      eval_result_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (responses_due.size() == 0) begin
            log_failure($sformatf("unexpected response value=%h status=%0d",
                                  rsp_value, rsp_status));
         end else begin
            due = responses_due.pop_front();
            if (rsp_value !== due.value || rsp_status !== due.status)
               log_failure($sformatf("mismatch: value exp %h got %h, status exp %0d got %0d",
                                     due.value, rsp_value, due.status, rsp_status));
         end
      end
   end

   // Watchdog: cycles with neither a request nor a response transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rpn_stack_evaluator_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int sequences;
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_PUSH;
      req_operand  = '0;
      req_operator = OP_ADD;
      failures     = 0;
      stall_cycles = 0;
      burst        = 1'b0;
      model_depth  = 0;
      sequences    = 0;
      foreach (model_stack[i]) model_stack[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i])
         issue_token(SCRIPT[i].action, SCRIPT[i].operand, SCRIPT[i].oper,
                     SCRIPT[i].typed_in, SCRIPT[i].value, SCRIPT[i].status);
      wait_all_responses();

      random_tokens = 0;
      while (random_tokens < RANDOM_TOKENS) begin
         if ($urandom_range(0, 5) == 0) burst = !burst;
         case ($urandom_range(0, 9))
            0:       run_deep_stack();
            1, 2:    run_noise();
            default: run_expression();
         endcase
         sequences++;
         if (sequences % 37 == 0) wait_all_responses();
      end

      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (responses_due.size() != 0)
         log_failure($sformatf("%0d responses never arrived", responses_due.size()));
      if (failures == 0) begin
         $display("tb_rpn_stack_evaluator_top: clean");
      end else begin
         $display("tb_rpn_stack_evaluator_top: errors");
      end
      $finish;
   end

endmodule
